/* sv/kpde_pkg.sv */
// Shared types, constants and lookup functions for the keypad entry and display block.
`default_nettype none

package kpde_pkg;

  localparam int unsigned COL_W      = 4;
  localparam int unsigned ROW_W      = 2;
  localparam int unsigned ROWS       = 4;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned SEG_W      = 7;
  localparam int unsigned ENABLE_W   = 4;
  localparam int unsigned COUNT_OUT_W = 3;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam logic [TICK_W-1:0] SETTLE_RESET  = 16'd2000;
  localparam logic [TICK_W-1:0] REFRESH_RESET = 16'd800;

  localparam logic [CFG_ADDR_W-1:0] REG_SETTLE  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_REFRESH = 1'd1;

  localparam logic [DIGIT_W-1:0] NO_KEY    = 4'hF;
  localparam logic [DIGIT_W-1:0] MAX_DIGIT = 4'd9;

  typedef enum logic [1:0] {
    PH_SETTLE  = 2'd0,
    PH_CONFIRM = 2'd1,
    PH_RELEASE = 2'd2,
    PH_AFTER   = 2'd3
  } scan_phase_t;

  // Write into the digit store, with a fixed three-bit index.
  typedef struct packed {
    logic               en;
    logic [2:0]         idx;
    logic [DIGIT_W-1:0] digit;
  } store_wr_t;

  function automatic logic [1:0] lowest_col(input logic [COL_W-1:0] c);
    logic [1:0] r;
    if (c[0])      r = 2'd0;
    else if (c[1]) r = 2'd1;
    else if (c[2]) r = 2'd2;
    else           r = 2'd3;
    return r;
  endfunction

  function automatic logic [DIGIT_W-1:0] key_lookup(input logic [ROW_W-1:0] row,
                                                    input logic [1:0] col);
    logic [DIGIT_W-1:0] k;
    case ({row, col})
      4'b00_00: k = 4'd1;
      4'b00_01: k = 4'd2;
      4'b00_10: k = 4'd3;
      4'b01_00: k = 4'd4;
      4'b01_01: k = 4'd5;
      4'b01_10: k = 4'd6;
      4'b10_00: k = 4'd7;
      4'b10_01: k = 4'd8;
      4'b10_10: k = 4'd9;
      4'b11_01: k = 4'd0;
      default:  k = NO_KEY;
    endcase
    return k;
  endfunction

  // Pattern bits a..g, bit 0 is segment a; codes above nine wrap modulo ten.
  function automatic logic [SEG_W-1:0] seg_lookup(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0, 4'd10: s = 7'h3F;
      4'd1, 4'd11: s = 7'h06;
      4'd2, 4'd12: s = 7'h5B;
      4'd3, 4'd13: s = 7'h4F;
      4'd4, 4'd14: s = 7'h66;
      4'd5, 4'd15: s = 7'h6D;
      4'd6:        s = 7'h7D;
      4'd7:        s = 7'h07;
      4'd8:        s = 7'h7F;
      4'd9:        s = 7'h6F;
      default:     s = 7'h3F;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* sv/kpde_scanner.sv */
// Row scanner with settle, confirm, release and after-release waits, and the digit entry count.
`default_nettype none

module kpde_scanner #(
  parameter int unsigned NUM_DIGITS = 4,
  parameter int unsigned CNT_W = 3,
  parameter int unsigned POS_W = 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          advance,
  input  wire logic [kpde_pkg::COL_W-1:0]    col_lines,
  input  wire logic [kpde_pkg::TICK_W-1:0]   settle_ticks,
  output logic [kpde_pkg::ROW_W-1:0]         row_index,
  output logic                               key_accepted,
  output logic [kpde_pkg::DIGIT_W-1:0]       key_digit,
  output logic [CNT_W-1:0]                   count_next,
  output kpde_pkg::store_wr_t                store_wr
);
  import kpde_pkg::*;

  scan_phase_t              scan_phase, scan_phase_next;
  logic [ROW_W-1:0]         row_next;
  logic [TICK_W-1:0]        wait_counter, wait_next;
  logic [CNT_W-1:0]         entry_count;
  logic [TICK_W-1:0]        limit;
  logic [TICK_W:0]          wait_inc;
  logic                     wait_done;
  logic                     pressed;
  logic [DIGIT_W-1:0]       key;
  logic                     take_key;

  assign limit     = (settle_ticks == '0) ? TICK_W'(1) : settle_ticks;
  assign wait_inc  = {1'b0, wait_counter} + (TICK_W+1)'(1);
  assign wait_done = wait_inc >= {1'b0, limit};
  assign pressed   = col_lines != '0;
  assign key       = key_lookup(row_index, lowest_col(col_lines));
  assign take_key  = advance && (scan_phase == PH_CONFIRM) && wait_done && pressed &&
                     (key <= MAX_DIGIT) && (entry_count < CNT_W'(NUM_DIGITS));

  // Next state of the scan sequence.
  always_comb begin
    scan_phase_next = scan_phase;
    row_next        = row_index;
    wait_next       = wait_done ? '0 : wait_inc[TICK_W-1:0];
    count_next      = take_key ? entry_count + CNT_W'(1) : entry_count;
    case (scan_phase)
      PH_SETTLE: begin
        if (wait_done) begin
          if (pressed) begin
            scan_phase_next = PH_CONFIRM;
          end else begin
            row_next = row_index + ROW_W'(1);
          end
        end
      end
      PH_CONFIRM: begin
        if (wait_done) begin
          if (pressed) begin
            scan_phase_next = PH_RELEASE;
          end else begin
            scan_phase_next = PH_SETTLE;
            row_next        = row_index + ROW_W'(1);
          end
        end
      end
      PH_RELEASE: begin
        wait_next = wait_counter;
        if (!pressed) begin
          scan_phase_next = PH_AFTER;
          wait_next       = '0;
        end
      end
      PH_AFTER: begin
        if (wait_done) begin
          scan_phase_next = PH_SETTLE;
          row_next        = row_index + ROW_W'(1);
        end
      end
      default: begin
        scan_phase_next = PH_SETTLE;
      end
    endcase
  end

  // Key event and store write.
  always_comb begin
    key_accepted   = take_key;
    key_digit      = take_key ? key : '0;
    store_wr.en    = take_key;
    store_wr.idx   = 3'(entry_count[POS_W-1:0]);
    store_wr.digit = key;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase   <= PH_SETTLE;
      row_index    <= '0;
      wait_counter <= '0;
      entry_count  <= '0;
    end else if (advance) begin
      scan_phase   <= scan_phase_next;
      row_index    <= row_next;
      wait_counter <= wait_next;
      entry_count  <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(NUM_DIGITS))
    else $error("entry count beyond digit store depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    take_key |=> entry_count == $past(entry_count) + CNT_W'(1))
    else $error("stored key did not advance the entry count");

  a_release_idle: assert property (@(posedge clk) disable iff (rst)
    scan_phase == PH_RELEASE |-> wait_counter == '0)
    else $error("wait counter running during release wait");

endmodule

`default_nettype wire

/* sv/kpde_display.sv */
// Digit store, refresh counter and seven-segment multiplexing.
`default_nettype none

module kpde_display #(
  parameter int unsigned NUM_DIGITS = 4,
  parameter int unsigned POS_W = 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          advance,
  input  wire logic [kpde_pkg::TICK_W-1:0]   refresh_ticks,
  input  wire kpde_pkg::store_wr_t           store_wr,
  output logic [kpde_pkg::SEG_W-1:0]         segments,
  output logic [kpde_pkg::ENABLE_W-1:0]      digit_enable
);
  import kpde_pkg::*;

  logic [DIGIT_W-1:0] digit_store [NUM_DIGITS];
  logic [TICK_W-1:0]  refresh_counter;
  logic [POS_W-1:0]   display_position;
  logic [TICK_W-1:0]  limit;
  logic [TICK_W:0]    refresh_inc;
  logic               refresh_done;
  logic [POS_W-1:0]   wr_idx;

  assign limit        = (refresh_ticks == '0) ? TICK_W'(1) : refresh_ticks;
  assign refresh_inc  = {1'b0, refresh_counter} + (TICK_W+1)'(1);
  assign refresh_done = refresh_inc >= {1'b0, limit};
  assign wr_idx       = store_wr.idx[POS_W-1:0];

  assign segments = seg_lookup(digit_store[display_position]);

  // Only the first four positions have an enable line.
  always_comb begin
    if (4'(display_position) < 4'(ENABLE_W)) begin
      digit_enable = ~(ENABLE_W'(1) << display_position);
    end else begin
      digit_enable = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_counter  <= '0;
      display_position <= '0;
    end else if (advance) begin
      if (refresh_done) begin
        refresh_counter <= '0;
        if (32'(display_position) == NUM_DIGITS - 1) begin
          display_position <= '0;
        end else begin
          display_position <= display_position + POS_W'(1);
        end
      end else begin
        refresh_counter <= refresh_inc[TICK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digit_store[i] <= '0;
      end
    end else if (store_wr.en) begin
      digit_store[wr_idx] <= store_wr.digit;
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    32'(display_position) < NUM_DIGITS)
    else $error("display position beyond digit count");

  a_pos_on_wrap: assert property (@(posedge clk) disable iff (rst)
    !$stable(display_position) |-> refresh_counter == '0)
    else $error("display position moved without refresh wrap");

  a_store_write: assert property (@(posedge clk) disable iff (rst)
    store_wr.en |=> digit_store[$past(wr_idx)] == $past(store_wr.digit))
    else $error("digit store write lost");

endmodule

`default_nettype wire

/* sv/keypad_digit_entry_display_top.sv */
// Top level of the keypad digit entry and display block.
//
// Each request on the s_axis channel is one tick of the keypad column lines.
// Every request yields exactly one result on m_axis: the row drive and the
// display segment and enable lines as they stood at the start of that tick,
// plus the key event of the tick and the digit count after it.
// A result is valid in the cycle after its request is taken. One request is
// taken per clock while the receiver does not stall; the whole tick is evaluated by
// the scanner and display logic between the state registers and the output
// register.
// When the receiver stalls, the output register holds the result and a new
// request is taken only once that result leaves, so s_axis_tready follows
// m_axis_tready while the output register is full.
// cfg_we writes settle_ticks (index 0) or refresh_ticks (index 1) from
// cfg_data; a value of zero acts as one.
// Reset clears the scanner to row 0 in its first settle wait, empties the
// digit store (all digits show 0), and restores the register defaults of
// 2000 and 800 ticks.
`default_nettype none

module keypad_digit_entry_display_top #(
  parameter int unsigned NUM_DIGITS = 4
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // [3:0] col_lines
  input  wire logic [kpde_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // [3:0] row_drive, [10:4] segments, [14:11] digit_enable, [15] key_accepted,
  // [19:16] key_digit, [22:20] stored_count
  output logic [kpde_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
  input  wire logic                                 cfg_we,
  input  wire logic [kpde_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [kpde_pkg::TICK_W-1:0]          cfg_data
);
  import kpde_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_DIGITS + 1);
  localparam int unsigned POS_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  logic [TICK_W-1:0]   settle_ticks;
  logic [TICK_W-1:0]   refresh_ticks;
  logic                advance;
  logic [COL_W-1:0]    col_lines;
  logic [ROW_W-1:0]    row_index;
  logic                key_accepted;
  logic [DIGIT_W-1:0]  key_digit;
  logic [CNT_W-1:0]    count_next;
  store_wr_t           store_wr;
  logic [SEG_W-1:0]    segments;
  logic [ENABLE_W-1:0] digit_enable;
  logic [ROWS-1:0]     row_drive;
  logic [OUT_TDATA_W-1:0] result;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign advance       = s_axis_tvalid && s_axis_tready;
  assign col_lines     = s_axis_tdata[COL_W-1:0];
  assign row_drive     = ROWS'(1) << row_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ticks  <= SETTLE_RESET;
      refresh_ticks <= REFRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SETTLE:  settle_ticks  <= cfg_data;
        REG_REFRESH: refresh_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  kpde_scanner #(
    .NUM_DIGITS (NUM_DIGITS),
    .CNT_W      (CNT_W),
    .POS_W      (POS_W)
  ) u_scanner (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .col_lines    (col_lines),
    .settle_ticks (settle_ticks),
    .row_index    (row_index),
    .key_accepted (key_accepted),
    .key_digit    (key_digit),
    .count_next   (count_next),
    .store_wr     (store_wr)
  );

  kpde_display #(
    .NUM_DIGITS (NUM_DIGITS),
    .POS_W      (POS_W)
  ) u_display (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .refresh_ticks (refresh_ticks),
    .store_wr      (store_wr),
    .segments      (segments),
    .digit_enable  (digit_enable)
  );

  assign result = {1'b0, COUNT_OUT_W'(count_next), key_digit, key_accepted,
                   digit_enable, segments, row_drive};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= result;
    end
  end

  a_one_enable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $onehot0(~m_axis_tdata[14:11]))
    else $error("more than one digit enabled");

  a_digit_only_on_key: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[15]) |-> m_axis_tdata[19:16] == '0)
    else $error("key digit set without a stored key");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_axis_tvalid)
    else $error("taken request produced no result");

endmodule

`default_nettype wire
